/* rtl/stim_current_session_sequencer_assert.svh */
// assertion helpers for the session sequencer checker
`ifndef STIM_CURRENT_SESSION_SEQUENCER_ASSERT_SVH
`define STIM_CURRENT_SESSION_SEQUENCER_ASSERT_SVH

// property checked only out of reset
`define SCSS_ASSERT(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("scss assertion failed");

// property checked at every edge, reset included
`define SCSS_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("scss assertion failed");

`endif

/* rtl/scss_pkg.sv */
`timescale 1ns / 1ps
package scss_pkg;

    localparam int unsigned CUR_W  = 15;
    localparam int unsigned MEAS_W = 16;
    localparam int unsigned MS_W   = 32;
    localparam int unsigned DAC_W  = 16;
    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [CUR_W-1:0] CUR_CAP  = 15'd19990;
    localparam logic [CUR_W-1:0] CUR_STEP = 15'd10;
    // 3.2852 in unsigned q2.16, rounded to nearest
    localparam logic [17:0] DAC_GAIN_Q16 = 18'd215299;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_CURRENT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HOLD_TIME_MS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMP_THRESHOLD = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_OPEN_FLOOR    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_OC_LIMIT      = 3'd4;

    // phase codes as seen on the result channel
    localparam logic [1:0] PH_CODE_UP   = 2'd0;
    localparam logic [1:0] PH_CODE_HOLD = 2'd1;
    localparam logic [1:0] PH_CODE_DOWN = 2'd2;
    localparam logic [1:0] PH_CODE_DONE = 2'd3;

    typedef enum logic [3:0] {
        PH_UP   = 4'b0001,
        PH_HOLD = 4'b0010,
        PH_DOWN = 4'b0100,
        PH_DONE = 4'b1000
    } t_phase;

    typedef enum logic [1:0] {
        FAULT_OK      = 2'd0,
        FAULT_HW_OC   = 2'd1,
        FAULT_OPEN    = 2'd2,
        FAULT_SW_OC   = 2'd3
    } t_fault;

    function automatic logic [1:0] phase_code(input t_phase ph);
        logic [1:0] code;
        case (ph)
            PH_UP:   code = PH_CODE_UP;
            PH_HOLD: code = PH_CODE_HOLD;
            PH_DOWN: code = PH_CODE_DOWN;
            PH_DONE: code = PH_CODE_DONE;
            default: code = PH_CODE_UP;
        endcase
        return code;
    endfunction

endpackage

/* rtl/scss_tick_if.sv */
`timescale 1ns / 1ps
interface scss_tick_if;
    import scss_pkg::*;

    logic              valid;
    logic              ready;
    logic              start_req;
    logic              abort;
    logic              hw_overcurrent;
    logic [MEAS_W-1:0] meas_current;
    logic [MS_W-1:0]   now_ms;

    modport source (
        output valid, start_req, abort, hw_overcurrent, meas_current, now_ms,
        input  ready
    );
    modport sink (
        input  valid, start_req, abort, hw_overcurrent, meas_current, now_ms,
        output ready
    );
endinterface

/* rtl/scss_result_if.sv */
`timescale 1ns / 1ps
interface scss_result_if;
    import scss_pkg::*;

    logic              valid;
    logic              ready;
    logic [CUR_W-1:0]  cmd_current;
    logic [DAC_W-1:0]  dac_code;
    logic              dac_write;
    logic              report_valid;
    logic [MEAS_W-1:0] measured_echo;
    logic [1:0]        phase;
    logic [1:0]        fault;

    modport source (
        output valid, cmd_current, dac_code, dac_write, report_valid,
               measured_echo, phase, fault,
        input  ready
    );
    modport sink (
        input  valid, cmd_current, dac_code, dac_write, report_valid,
               measured_echo, phase, fault,
        output ready
    );
endinterface

/* rtl/stim_current_session_sequencer.sv */
`timescale 1ns / 1ps
// stimulation current session sequencer
// i_tick: one transfer per timer tick with start/abort requests, the hardware
//   overcurrent flag, the measured electrode current and the millisecond time
// o_result: one transfer per tick with the commanded current, its dac code and
//   write strobe, the report fields, the session phase after the tick and the
//   highest-priority fault
// i_cfg_*: register writes (plateau current, hold time, fault thresholds); the
//   user must make them only while no tick is in flight, the block does not enforce this
// datapath: a taken tick sits in the input register, is stepped by the phase
//   logic and the dac multiplier, and lands in the result register
// throughput: one tick per cycle while o_result does not stall; the session
//   state is updated as the tick leaves the input register, so consecutive
//   ticks see each other's update
// reset: phase ramp-up, current 0, hold start 0, registers at their defaults,
//   both pipeline stages empty
// stall: a result waiting on o_result.ready holds; one more tick can still be
//   taken into the input register, after which i_tick.ready drops
module stim_current_session_sequencer (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    scss_tick_if.sink                      i_tick,
    scss_result_if.source                  o_result,
    input  logic                           i_cfg_we,
    input  logic [scss_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [scss_pkg::CFG_DATA_W-1:0] i_cfg_wdata
);
    import scss_pkg::*;

    // configuration registers
    logic [CUR_W-1:0]  r_max_current;
    logic [MS_W-1:0]   r_hold_time_ms;
    logic [CUR_W-1:0]  r_imp_threshold;
    logic [MEAS_W-1:0] r_open_floor;
    logic [MEAS_W-1:0] r_oc_limit;

    // session state
    t_phase            r_phase;
    logic [CUR_W-1:0]  r_cur;
    logic [MS_W-1:0]   r_hold_start;

    // input register
    logic              r_in_valid;
    logic              r_in_start;
    logic              r_in_abort;
    logic              r_in_hw;
    logic [MEAS_W-1:0] r_in_meas;
    logic [MS_W-1:0]   r_in_now;

    // result register
    logic              r_out_valid;
    logic [CUR_W-1:0]  r_out_cur;
    logic [DAC_W-1:0]  r_out_dac;
    logic              r_out_wr;
    logic              r_out_rep;
    logic [MEAS_W-1:0] r_out_meas;
    logic [1:0]        r_out_phase;
    t_fault            r_out_fault;

    // step logic
    t_phase            n_phase;
    logic [CUR_W-1:0]  n_cur;
    logic [MS_W-1:0]   n_hold_start;
    t_phase            w_ph0;
    logic [CUR_W-1:0]  w_cur0;
    logic [CUR_W:0]    w_sum;
    logic [MS_W-1:0]   w_elapsed;
    logic              w_wr;
    logic              w_rep;
    t_fault            w_fault;
    logic [CUR_W-1:0]  w_cur_clamp;
    logic [32:0]       w_prod;
    logic [DAC_W:0]    w_code_wide;
    logic [DAC_W-1:0]  w_dac;
    logic              w_adv;
    logic              w_tick_xfer;

    // input stage moves on when the result register is free or being emptied
    assign w_adv       = r_in_valid && (!r_out_valid || o_result.ready);
    assign i_tick.ready = !r_in_valid || w_adv;
    assign w_tick_xfer = i_tick.valid && i_tick.ready;

    // one tick: start, then abort, then the phase step
    always_comb begin
        w_cur0 = r_in_start ? '0 : r_cur;
        w_ph0  = r_in_start ? PH_UP : r_phase;
        if (r_in_abort) begin
            w_ph0 = PH_DOWN;
        end
        w_sum        = {1'b0, w_cur0} + {1'b0, CUR_STEP};
        w_elapsed    = r_in_now - r_hold_start;
        n_phase      = w_ph0;
        n_cur        = w_cur0;
        n_hold_start = r_hold_start;
        w_wr         = 1'b0;
        w_rep        = 1'b0;
        case (w_ph0)
            PH_UP: begin
                n_cur = (w_sum > {1'b0, CUR_CAP}) ? CUR_CAP : w_sum[CUR_W-1:0];
                w_wr  = 1'b1;
                w_rep = 1'b1;
                if (n_cur >= r_max_current || n_cur >= CUR_CAP) begin
                    n_phase      = PH_HOLD;
                    n_hold_start = r_in_now;
                end
            end
            PH_HOLD: begin
                w_rep = 1'b1;
                if (w_elapsed >= r_hold_time_ms) begin
                    n_phase = PH_DOWN;
                end
            end
            PH_DOWN: begin
                n_cur = (w_cur0 > CUR_STEP) ? (w_cur0 - CUR_STEP) : '0;
                w_wr  = 1'b1;
                w_rep = 1'b1;
                if (n_cur <= CUR_STEP) begin
                    n_phase = PH_DONE;
                end
            end
            PH_DONE: begin
            end
            default: begin
            end
        endcase
    end

    // fault check on the stepped current, hardware alarm first
    always_comb begin
        if (r_in_hw) begin
            w_fault = FAULT_HW_OC;
        end else if (n_cur > r_imp_threshold && r_in_meas < r_open_floor) begin
            w_fault = FAULT_OPEN;
        end else if (r_in_meas > r_oc_limit) begin
            w_fault = FAULT_SW_OC;
        end else begin
            w_fault = FAULT_OK;
        end
    end

    // dac code: clamp, scale by the q2.16 gain, truncate, saturate
    assign w_cur_clamp = (n_cur > CUR_CAP) ? CUR_CAP : n_cur;
    assign w_prod      = 33'(w_cur_clamp) * 33'(DAC_GAIN_Q16);
    assign w_code_wide = w_prod[32:16];
    assign w_dac       = w_code_wide[DAC_W] ? '1 : w_code_wide[DAC_W-1:0];

    // control and state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_current   <= '0;
            r_hold_time_ms  <= '0;
            r_imp_threshold <= 15'd500;
            r_open_floor    <= 16'd100;
            r_oc_limit      <= 16'd20000;
            r_phase         <= PH_UP;
            r_cur           <= '0;
            r_hold_start    <= '0;
            r_in_valid      <= 1'b0;
            r_out_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MAX_CURRENT:   r_max_current   <= i_cfg_wdata[CUR_W-1:0];
                    CFG_HOLD_TIME_MS:  r_hold_time_ms  <= i_cfg_wdata[MS_W-1:0];
                    CFG_IMP_THRESHOLD: r_imp_threshold <= i_cfg_wdata[CUR_W-1:0];
                    CFG_OPEN_FLOOR:    r_open_floor    <= i_cfg_wdata[MEAS_W-1:0];
                    CFG_OC_LIMIT:      r_oc_limit      <= i_cfg_wdata[MEAS_W-1:0];
                    default: begin
                    end
                endcase
            end
            if (w_adv) begin
                r_phase      <= n_phase;
                r_cur        <= n_cur;
                r_hold_start <= n_hold_start;
            end
            if (w_tick_xfer) begin
                r_in_valid <= 1'b1;
            end else if (w_adv) begin
                r_in_valid <= 1'b0;
            end
            if (w_adv) begin
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_tick_xfer) begin
            r_in_start <= i_tick.start_req;
            r_in_abort <= i_tick.abort;
            r_in_hw    <= i_tick.hw_overcurrent;
            r_in_meas  <= i_tick.meas_current;
            r_in_now   <= i_tick.now_ms;
        end
        if (w_adv) begin
            r_out_cur   <= n_cur;
            r_out_dac   <= w_dac;
            r_out_wr    <= w_wr;
            r_out_rep   <= w_rep;
            r_out_meas  <= w_rep ? r_in_meas : '0;
            r_out_phase <= phase_code(n_phase);
            r_out_fault <= w_fault;
        end
    end

    assign o_result.valid         = r_out_valid;
    assign o_result.cmd_current   = r_out_cur;
    assign o_result.dac_code      = r_out_dac;
    assign o_result.dac_write     = r_out_wr;
    assign o_result.report_valid  = r_out_rep;
    assign o_result.measured_echo = r_out_meas;
    assign o_result.phase         = r_out_phase;
    assign o_result.fault         = r_out_fault;

endmodule

/* rtl/scss_check.sv */
`timescale 1ns / 1ps
`include "stim_current_session_sequencer_assert.svh"
module scss_check (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_out_valid,
    input logic                       i_out_ready,
    input logic [scss_pkg::CUR_W-1:0] i_cmd_current,
    input logic                       i_dac_write,
    input logic                       i_report_valid,
    input logic [scss_pkg::MEAS_W-1:0] i_measured_echo,
    input logic [1:0]                 i_phase
);
    import scss_pkg::*;

    // a stalled result keeps its current
    `SCSS_ASSERT(a_stall_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_cmd_current))
    // commanded current never passes the ramp cap
    `SCSS_ASSERT(a_cur_cap, i_clk, i_rst_n, i_out_valid |-> i_cmd_current <= CUR_CAP)
    // a tick that reports nothing leaves the session complete and writes nothing
    `SCSS_ASSERT(a_done_quiet, i_clk, i_rst_n, i_out_valid && !i_report_valid |-> i_phase == PH_CODE_DONE && !i_dac_write && i_measured_echo == '0)
    // every dac write goes with a report
    `SCSS_ASSERT(a_wr_rep, i_clk, i_rst_n, i_out_valid && i_dac_write |-> i_report_valid)
    // reset empties the result channel
    `SCSS_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !i_out_valid)

endmodule

bind stim_current_session_sequencer scss_check u_scss_check (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_out_valid     (o_result.valid),
    .i_out_ready     (o_result.ready),
    .i_cmd_current   (o_result.cmd_current),
    .i_dac_write     (o_result.dac_write),
    .i_report_valid  (o_result.report_valid),
    .i_measured_echo (o_result.measured_echo),
    .i_phase         (o_result.phase)
);

/* tb/testbench.sv */
`timescale 1ns / 1ps
module testbench;
    import scss_pkg::*;

    // one tick as offered on the input channel
    typedef struct packed {
        logic              start_req;
        logic              abort;
        logic              hw_overcurrent;
        logic [MEAS_W-1:0] meas_current;
        logic [MS_W-1:0]   now_ms;
    } t_tick_item;

    // one result as seen on the output channel
    typedef struct packed {
        logic [CUR_W-1:0]  cmd_current;
        logic [DAC_W-1:0]  dac_code;
        logic              dac_write;
        logic              report_valid;
        logic [MEAS_W-1:0] measured_echo;
        logic [1:0]        phase;
        t_fault            fault;
    } t_session_result;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;

    scss_tick_if   tick_if ();
    scss_result_if res_if ();

    stim_current_session_sequencer i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_tick      (tick_if),
        .o_result    (res_if),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #1 i_clk = ~i_clk;

    // ticks waiting for the driver, results waiting for the monitor
    t_tick_item      pending_ticks[$];
    t_session_result expected_results[$];
    int              mismatches = 0;

    // predicted session state, starts at its reset value
    logic [1:0]       sess_phase      = PH_CODE_UP;
    logic [CUR_W-1:0] sess_current    = '0;
    logic [MS_W-1:0]  sess_hold_start = '0;

    // predicted register contents, reset defaults
    logic [CUR_W-1:0]  cfg_max_current = 15'd0;
    logic [MS_W-1:0]   cfg_hold_ms     = 32'd0;
    logic [CUR_W-1:0]  cfg_imp_thr     = 15'd500;
    logic [MEAS_W-1:0] cfg_open_floor  = 16'd100;
    logic [MEAS_W-1:0] cfg_oc_limit    = 16'd20000;

    // running millisecond time used by the stimulus
    logic [MS_W-1:0] clock_ms = '0;

    // dac word: clamp, scale by the q2.16 gain, truncate, saturate
    function automatic logic [DAC_W-1:0] dac_code_of(input logic [CUR_W-1:0] cur);
        longint unsigned clamped;
        longint unsigned scaled;
        clamped = (cur > CUR_CAP) ? CUR_CAP : cur;
        scaled  = (clamped * DAC_GAIN_Q16) >> 16;
        return (scaled > 65535) ? 16'hFFFF : scaled[15:0];
    endfunction

    // advance the predicted session by one tick and build its result
    function automatic t_session_result step_session(input t_tick_item t);
        t_session_result r;
        logic [CUR_W:0]  raised;
        logic [MS_W-1:0] elapsed;
        r = '0;
        // start first, then abort overrides the phase
        if (t.start_req) begin
            sess_current = '0;
            sess_phase   = PH_CODE_UP;
        end
        if (t.abort)
            sess_phase = PH_CODE_DOWN;

        case (sess_phase)
            PH_CODE_UP: begin
                raised = {1'b0, sess_current} + CUR_STEP;
                sess_current = (raised > CUR_CAP) ? CUR_CAP : raised[CUR_W-1:0];
                r.dac_write    = 1'b1;
                r.report_valid = 1'b1;
                // hitting the cap counts as reaching the plateau
                if (sess_current >= cfg_max_current || sess_current >= CUR_CAP) begin
                    sess_phase      = PH_CODE_HOLD;
                    sess_hold_start = t.now_ms;
                end
            end
            PH_CODE_HOLD: begin
                r.report_valid = 1'b1;
                elapsed = t.now_ms - sess_hold_start;
                if (elapsed >= cfg_hold_ms)
                    sess_phase = PH_CODE_DOWN;
            end
            PH_CODE_DOWN: begin
                sess_current = (sess_current > CUR_STEP) ? sess_current - CUR_STEP : '0;
                r.dac_write    = 1'b1;
                r.report_valid = 1'b1;
                if (sess_current <= CUR_STEP)
                    sess_phase = PH_CODE_DONE;
            end
            default: ;
        endcase

        // fault priority: hardware, open electrodes, software overcurrent
        if (t.hw_overcurrent)
            r.fault = FAULT_HW_OC;
        else if (sess_current > cfg_imp_thr && t.meas_current < cfg_open_floor)
            r.fault = FAULT_OPEN;
        else if (t.meas_current > cfg_oc_limit)
            r.fault = FAULT_SW_OC;
        else
            r.fault = FAULT_OK;

        r.cmd_current   = sess_current;
        r.dac_code      = dac_code_of(sess_current);
        r.measured_echo = r.report_valid ? t.meas_current : '0;
        r.phase         = sess_phase;
        return r;
    endfunction

    // ---------------------------------------------------------------
    // driver: bursts of random length, random gaps between them
    // ---------------------------------------------------------------
    t_tick_item driven_tick;
    int         burst_left = 0;
    int         gap_left   = 0;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tick_if.valid <= 1'b0;
        end else begin
            // a tick transfer: predict its result now, in acceptance order
            if (tick_if.valid && tick_if.ready)
                expected_results.push_back(step_session(driven_tick));

            if (tick_if.valid && !tick_if.ready) begin
                // stalled, payload and valid stay as they are
            end else if (gap_left > 0) begin
                gap_left--;
                tick_if.valid <= 1'b0;
            end else if (pending_ticks.size() != 0) begin
                driven_tick = pending_ticks.pop_front();
                tick_if.start_req      <= driven_tick.start_req;
                tick_if.abort          <= driven_tick.abort;
                tick_if.hw_overcurrent <= driven_tick.hw_overcurrent;
                tick_if.meas_current   <= driven_tick.meas_current;
                tick_if.now_ms         <= driven_tick.now_ms;
                tick_if.valid          <= 1'b1;
                // end of burst: pick the next burst and the gap before it
                if (burst_left <= 1) begin
                    burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                             : $urandom_range(1, 30);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left--;
                end
            end else begin
                tick_if.valid <= 1'b0;
            end
        end
    end

    // ---------------------------------------------------------------
    // monitor: compares each result transfer, stalls on its own pattern
    // ---------------------------------------------------------------
    int stall_mode = 0;
    int stall_left = 0;

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin : result_monitor
        t_session_result want;
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (expected_results.size() == 0) begin
                    $error("result transfer with no tick outstanding");
                    mismatches++;
                end else begin
                    want = expected_results.pop_front();
                    check_field("cmd_current", 32'(want.cmd_current),
                                32'(res_if.cmd_current));
                    check_field("dac_code", 32'(want.dac_code), 32'(res_if.dac_code));
                    check_field("dac_write", 32'(want.dac_write), 32'(res_if.dac_write));
                    check_field("report_valid", 32'(want.report_valid),
                                32'(res_if.report_valid));
                    check_field("measured_echo", 32'(want.measured_echo),
                                32'(res_if.measured_echo));
                    check_field("phase", 32'(want.phase), 32'(res_if.phase));
                    check_field("fault", 32'(want.fault), 32'(res_if.fault));
                end
            end

            // stall pattern: always ready, light, heavy or periodic
            if (stall_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_left = $urandom_range(8, 64);
            end else begin
                stall_left--;
            end
            case (stall_mode)
                0:       res_if.ready <= 1'b1;
                1:       res_if.ready <= ($urandom_range(0, 3) != 0);
                2:       res_if.ready <= ($urandom_range(0, 5) == 0);
                default: res_if.ready <= (stall_left % 4 != 0);
            endcase
        end
    end

    // ---------------------------------------------------------------
    // stimulus helpers
    // ---------------------------------------------------------------
    task automatic add_tick(input logic start, input logic abrt, input logic hw,
                            input logic [MEAS_W-1:0] meas, input logic [MS_W-1:0] now);
        t_tick_item t;
        t.start_req      = start;
        t.abort          = abrt;
        t.hw_overcurrent = hw;
        t.meas_current   = meas;
        t.now_ms         = now;
        pending_ticks.push_back(t);
    endtask

    // wait until every tick is in and every result is out, then let the pipe settle
    task automatic wait_idle();
        do
            @(negedge i_clk);
        while (pending_ticks.size() != 0 || tick_if.valid || expected_results.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        // block is idle, so the predicted copy can change right away
        case (idx)
            CFG_MAX_CURRENT:   cfg_max_current = value[CUR_W-1:0];
            CFG_HOLD_TIME_MS:  cfg_hold_ms     = value;
            CFG_IMP_THRESHOLD: cfg_imp_thr     = value[CUR_W-1:0];
            CFG_OPEN_FLOOR:    cfg_open_floor  = value[MEAS_W-1:0];
            CFG_OC_LIMIT:      cfg_oc_limit    = value[MEAS_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_config(input logic [31:0] max_cur, input logic [31:0] hold_ms,
                              input logic [31:0] imp_thr, input logic [31:0] open_floor,
                              input logic [31:0] oc_limit);
        write_reg(CFG_MAX_CURRENT, max_cur);
        write_reg(CFG_HOLD_TIME_MS, hold_ms);
        write_reg(CFG_IMP_THRESHOLD, imp_thr);
        write_reg(CFG_OPEN_FLOOR, open_floor);
        write_reg(CFG_OC_LIMIT, oc_limit);
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        @(negedge i_clk);
    endtask

    // random setting, extremes weighted in
    task automatic random_config();
        logic [31:0] v_max, v_hold, v_thr, v_floor, v_limit;
        case ($urandom_range(0, 7))
            0:       v_max = 0;
            1:       v_max = 32767;
            2:       v_max = 19990;
            default: v_max = $urandom_range(0, 250);
        endcase
        case ($urandom_range(0, 7))
            0:       v_hold = 0;
            1:       v_hold = 32'hFFFF_FFFF;
            2:       v_hold = $urandom;
            default: v_hold = $urandom_range(1, 30);
        endcase
        case ($urandom_range(0, 7))
            0:       v_thr = 0;
            1:       v_thr = 32767;
            default: v_thr = $urandom_range(0, 300);
        endcase
        case ($urandom_range(0, 7))
            0:       v_floor = 0;
            1:       v_floor = 65535;
            default: v_floor = $urandom_range(0, 3000);
        endcase
        case ($urandom_range(0, 7))
            0:       v_limit = 0;
            1:       v_limit = 65535;
            default: v_limit = $urandom_range(1000, 65535);
        endcase
        set_config(v_max, v_hold, v_thr, v_floor, v_limit);
    endtask

    // sessions: a start, then a run of ticks with random content;
    // noisy mode throws start and abort at random
    task automatic queue_sessions(input int n_items, input bit noisy);
        int         left;
        t_tick_item t;
        left = 0;
        if ($urandom_range(0, 3) == 0)
            clock_ms = 32'hFFFF_FF00;
        for (int k = 0; k < n_items; k++) begin
            t = '0;
            if (left == 0) begin
                t.start_req = 1'b1;
                left = $urandom_range(4, 60);
            end else begin
                left--;
            end
            if (noisy) begin
                t.start_req = 1'($urandom_range(0, 1));
                t.abort     = 1'($urandom_range(0, 1));
            end else begin
                if ($urandom_range(0, 49) == 0)
                    t.start_req = 1'b1;
                if ($urandom_range(0, 29) == 0)
                    t.abort = 1'b1;
            end
            t.hw_overcurrent = ($urandom_range(0, 11) == 0) || (noisy && $urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0:          t.meas_current = '0;
                1:          t.meas_current = 16'hFFFF;
                2, 3, 4, 5: t.meas_current = 16'($urandom_range(0, 3000));
                default:    t.meas_current = 16'($urandom);
            endcase
            // mostly small steps, now and then a big jump in time
            case ($urandom_range(0, 19))
                0:       clock_ms = $urandom;
                1:       clock_ms += $urandom_range(1000, 100000);
                default: clock_ms += $urandom_range(0, 4);
            endcase
            t.now_ms = clock_ms;
            pending_ticks.push_back(t);
        end
    endtask

    // ---------------------------------------------------------------
    // test sequence
    // ---------------------------------------------------------------
    initial begin
        i_rst_n                = 1'b0;
        i_cfg_we               = 1'b0;
        i_cfg_idx              = '0;
        i_cfg_wdata            = '0;
        tick_if.valid          = 1'b0;
        tick_if.start_req      = 1'b0;
        tick_if.abort          = 1'b0;
        tick_if.hw_overcurrent = 1'b0;
        tick_if.meas_current   = '0;
        tick_if.now_ms         = '0;
        res_if.ready           = 1'b0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset defaults: zero plateau goes straight to hold, zero hold ends at once
        add_tick(1'b0, 1'b0, 1'b0, 16'd0, 32'd0);
        add_tick(1'b0, 1'b0, 1'b0, 16'hFFFF, 32'hFFFF_FFFF);
        add_tick(1'b0, 1'b0, 1'b1, 16'd20000, 32'd1);
        add_tick(1'b0, 1'b0, 1'b0, 16'd20001, 32'd2);
        // abort in complete, then start together with abort
        add_tick(1'b0, 1'b1, 1'b0, 16'd99, 32'd3);
        add_tick(1'b1, 1'b1, 1'b0, 16'd100, 32'd4);
        add_tick(1'b1, 1'b0, 1'b1, 16'hFFFF, 32'd5);
        wait_idle();

        // short plateau, hold across the millisecond wrap, open and sw faults
        set_config(32'd40, 32'd5, 32'd15, 32'd1000, 32'd60000);
        add_tick(1'b1, 1'b0, 1'b0, 16'd500, 32'hFFFF_FFFA);
        add_tick(1'b0, 1'b0, 1'b0, 16'd500, 32'hFFFF_FFFB);
        add_tick(1'b0, 1'b0, 1'b1, 16'd0, 32'hFFFF_FFFC);
        add_tick(1'b0, 1'b0, 1'b0, 16'd999, 32'hFFFF_FFFD);
        add_tick(1'b0, 1'b0, 1'b0, 16'd60001, 32'hFFFF_FFFF);
        add_tick(1'b0, 1'b0, 1'b0, 16'd1000, 32'd1);
        add_tick(1'b0, 1'b0, 1'b0, 16'd32768, 32'd2);
        add_tick(1'b0, 1'b0, 1'b0, 16'd0, 32'd3);
        add_tick(1'b0, 1'b0, 1'b0, 16'd0, 32'd4);
        add_tick(1'b0, 1'b0, 1'b0, 16'd0, 32'd5);
        add_tick(1'b0, 1'b0, 1'b0, 16'd12345, 32'd6);
        // abort during ramp-up, start during hold
        add_tick(1'b1, 1'b0, 1'b0, 16'd0, 32'd7);
        add_tick(1'b0, 1'b1, 1'b0, 16'h5555, 32'h5555_5555);
        add_tick(1'b1, 1'b0, 1'b0, 16'hAAAA, 32'hAAAA_AAAA);
        add_tick(1'b0, 1'b0, 1'b0, 16'd1, 32'hAAAA_AAAB);
        add_tick(1'b0, 1'b0, 1'b0, 16'd2, 32'hAAAA_AAAC);
        add_tick(1'b0, 1'b0, 1'b0, 16'd3, 32'hAAAA_AAAD);
        add_tick(1'b1, 1'b0, 1'b0, 16'd4, 32'hAAAA_AAAE);
        wait_idle();

        // low and high extremes of every register
        set_config(32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        queue_sessions(80, 1'b0);
        wait_idle();
        set_config(32'd32767, 32'hFFFF_FFFF, 32'd32767, 32'd65535, 32'd65535);
        queue_sessions(80, 1'b0);
        wait_idle();

        // one long climb to a high plateau, a short hold and part of the ramp-down
        set_config(32'd1500, 32'd4, 32'd1000, 32'd40000, 32'd50000);
        clock_ms = $urandom;
        add_tick(1'b1, 1'b0, 1'b0, 16'($urandom), clock_ms);
        for (int k = 0; k < 200; k++) begin
            clock_ms += 1;
            add_tick(1'b0, 1'b0, 1'b0, 16'($urandom), clock_ms);
        end
        wait_idle();

        // random settings with well-formed sessions, then a noisy phase
        for (int p = 0; p < 4; p++) begin
            random_config();
            queue_sessions(80, 1'b0);
            wait_idle();
        end
        random_config();
        queue_sessions(60, 1'b1);
        wait_idle();

        repeat (10) @(posedge i_clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // watchdog well beyond the slowest legal run
    initial begin
        #2000000;
        $display("FAILED: results differ");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl
rtl/scss_pkg.sv
rtl/scss_tick_if.sv
rtl/scss_result_if.sv
rtl/stim_current_session_sequencer.sv
rtl/scss_check.sv
tb/testbench.sv
